[rtl/tsol_pkg.sv]
// Shared types and constants for the transpose self-organizing list.
package tsol_pkg;

   localparam int KEY_WIDTH        = 8;
   localparam int STATUS_WIDTH     = 2;
   localparam int POSITION_WIDTH   = 4;
   localparam int TOTAL_WIDTH      = 5;
   localparam int DEFAULT_CAPACITY = 16;
   localparam int DEFAULT_KEY_BITS = 8;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_MOVED    = 2'd0,
      ST_FIRST    = 2'd1,
      ST_APPENDED = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   // Per-cell load command for one update.
   typedef struct packed {
      logic load_key;
      logic load_prev;
   } cell_cmd_type;

   // Summary of the match row.
   typedef struct packed {
      logic                      hit;
      logic                      first;
      logic [POSITION_WIDTH-1:0] index;
   } hit_info_type;

endpackage

[rtl/tsol_req_if.sv]
// Request channel: one key per handshake.
interface tsol_req_if import tsol_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [KEY_WIDTH-1:0] key;

   modport source (output valid, output key, input ready);
   modport sink   (input valid, input key, output ready);
endinterface

[rtl/tsol_rsp_if.sv]
// Response channel: status, position and entry total per request.
interface tsol_rsp_if import tsol_pkg::*; ();
   logic                      valid;
   logic                      ready;
   status_type                status;
   logic [POSITION_WIDTH-1:0] position;
   logic [TOTAL_WIDTH-1:0]    entry_total;

   modport source (output valid, output status, output position, output entry_total,
                   input ready);
   modport sink   (input valid, input status, input position, input entry_total,
                   output ready);
endinterface

[rtl/tsol_cell.sv]
// One list cell: holds an entry, compares it with the key, loads from key or neighbor.
module tsol_cell import tsol_pkg::*; #(
   parameter int KEY_BITS = DEFAULT_KEY_BITS
) (
   input  logic                clock,
   input  logic [KEY_BITS-1:0] key,
   input  logic [KEY_BITS-1:0] prev_entry,
   input  logic                in_range,
   input  cell_cmd_type        cmd,
   output logic [KEY_BITS-1:0] entry,
   output logic                match
);

   logic [KEY_BITS-1:0] entry_ff;
   logic [KEY_BITS-1:0] entry_in;

   assign match = in_range && (entry_ff == key);
   assign entry = entry_ff;

   always_comb begin
      if (cmd.load_key) begin
         entry_in = key;
      end else if (cmd.load_prev) begin
         entry_in = prev_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

[rtl/tsol_match_reduce.sv]
// Collapse the one-hot match row into hit, head-hit and low index bits.
module tsol_match_reduce import tsol_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic [CAPACITY-1:0] match,
   output hit_info_type        info
);

   logic [POSITION_WIDTH-1:0] index;

   // Entries below the count are unique, so at most one bit is set.
   always_comb begin
      index = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (match[i]) begin
            index = index | POSITION_WIDTH'(i);
         end
      end
   end

   assign info.hit   = |match;
   assign info.first = match[0];
   assign info.index = index;

endmodule

[rtl/transpose_self_organizing_list.sv]
// Self-organizing list (transpose heuristic) built as a row of compare-and-swap cells.
// A response is registered and appears in the cycle after its request is taken.
// Throughput: one request per cycle while the response side keeps up; the cell row compares, swaps or appends.
// A waiting response does not block the next request while the response side takes it.
// Reset (synchronous, active high) clears the entry count and the response valid;
// the cell contents are not cleared and are only read below the count.
module transpose_self_organizing_list import tsol_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY,
   parameter int KEY_BITS = DEFAULT_KEY_BITS
) (
   input  logic       clock,
   input  logic       reset,
   tsol_req_if.sink   req_ch,
   tsol_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   status_type          status_ff;
   status_type          status_in;
   logic [POSITION_WIDTH-1:0] position_ff;
   logic [POSITION_WIDTH-1:0] position_in;
   logic [TOTAL_WIDTH-1:0]    total_ff;
   logic [TOTAL_WIDTH-1:0]    total_in;

   logic                fire;
   logic                full;
   logic                do_append;
   logic [KEY_BITS-1:0] key;
   logic [KEY_BITS-1:0] entry [CAPACITY];
   logic [CAPACITY-1:0] match;
   logic [CAPACITY-1:0] in_range;
   cell_cmd_type        cmd [CAPACITY];
   hit_info_type        info;

   // Take a new request whenever the response register is empty or draining.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;

   // Fit the key field to the stored key width.
   assign key = KEY_BITS'(req_ch.key);

   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign do_append = !info.hit && !full;

   // Cell row: each cell sees its left neighbor's entry and its right neighbor's match.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [KEY_BITS-1:0] prev_entry;
      logic                next_match;

      if (i == 0) begin : g_head
         assign prev_entry = entry[0];
      end else begin : g_body
         assign prev_entry = entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_match = 1'b0;
      end else begin : g_inner
         assign next_match = match[i+1];
      end

      assign in_range[i] = CNT_W'(i) < count_ff;

      // A hit one place down moves the key here; a hit here pulls the left entry down.
      // The head cell never moves on its own hit.
      assign cmd[i].load_key  = fire && (next_match ||
                                         (do_append && (count_ff == CNT_W'(i))));
      assign cmd[i].load_prev = fire && match[i] && (i != 0);

      tsol_cell #(
         .KEY_BITS (KEY_BITS)
      ) u_cell (
         .clock      (clock),
         .key        (key),
         .prev_entry (prev_entry),
         .in_range   (in_range[i]),
         .cmd        (cmd[i]),
         .entry      (entry[i]),
         .match      (match[i])
      );
   end

   tsol_match_reduce #(
      .CAPACITY (CAPACITY)
   ) u_reduce (
      .match (match),
      .info  (info)
   );

   // Response fields and count update for the request being taken.
   always_comb begin
      count_in    = count_ff;
      status_in   = status_ff;
      position_in = position_ff;
      total_in    = total_ff;
      if (fire) begin
         if (info.hit && info.first) begin
            status_in   = ST_FIRST;
            position_in = '0;
         end else if (info.hit) begin
            // Index is kept modulo the field width, so subtract there.
            status_in   = ST_MOVED;
            position_in = info.index - POSITION_WIDTH'(1);
         end else if (full) begin
            status_in   = ST_DROPPED;
            position_in = '0;
         end else begin
            status_in   = ST_APPENDED;
            position_in = POSITION_WIDTH'(count_ff);
            count_in    = count_ff + CNT_W'(1);
         end
         total_in = TOTAL_WIDTH'(count_in);
      end
   end

   // Hold the response until taken; load it on every accepted request.
   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      position_ff <= position_in;
      total_ff    <= total_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.position    = position_ff;
   assign rsp_ch.entry_total = total_ff;

endmodule

[sim/transpose_self_organizing_list_tb.sv]
// Testbench for the transpose self-organizing list: directed and random keys checked against a shadow list.
`timescale 1ns / 100ps

module transpose_self_organizing_list_tb;
   import tsol_pkg::*;

   localparam int CAPACITY   = DEFAULT_CAPACITY;
   localparam int KEY_BITS   = DEFAULT_KEY_BITS;
   localparam int RANDOM_KEYS = 1500;
   // Hold the sender here until every outstanding response has drained.
   localparam int DRAIN_AT   = 700;
   // Start no new idle or stall bursts once fewer than this many requests remain.
   localparam int QUIET_TAIL = 150;
   localparam int END_WAIT   = 2000;

   // One expected response: what the list reports after a request.
   typedef struct {
      status_type                status;
      logic [POSITION_WIDTH-1:0] position;
      logic [TOTAL_WIDTH-1:0]    entry_total;
   } list_outcome_type;

   logic clock;
   logic reset;

   tsol_req_if req_if ();
   tsol_rsp_if rsp_if ();

   transpose_self_organizing_list #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Sixteen distinct keys that fill the list; together they toggle every key bit.
   logic [KEY_WIDTH-1:0] fill_keys [CAPACITY] = '{
      8'h00, 8'hFF, 8'hAA, 8'h55, 8'h01, 8'h80, 8'h0F, 8'hF0,
      8'h33, 8'hCC, 8'h7F, 8'hFE, 8'h10, 8'h20, 8'h40, 8'h08
   };

   logic [KEY_WIDTH-1:0] pending_keys [$];
   list_outcome_type     expected_outcomes [$];

   // Shadow copy of the list contents and its length.
   logic [KEY_BITS-1:0] shadow_keys [CAPACITY];
   int                  shadow_count;

   int  accepted_count;
   int  answered_count;
   int  mismatch_count;
   bit  quiet_phase;
   bit  drain_done;

   // Apply one key to the shadow list and return the response it must produce.
   function automatic void promote_key(input logic [KEY_WIDTH-1:0] key,
                                       output list_outcome_type res);
      int                  hit;
      logic [KEY_BITS-1:0] k;
      logic [KEY_BITS-1:0] swap_key;
      k   = key[KEY_BITS-1:0];
      hit = -1;
      // Lowest matching index wins, and only entries below the count are looked at.
      for (int i = 0; i < shadow_count && i < CAPACITY; i++) begin
         if (hit < 0 && shadow_keys[i] == k) hit = i;
      end
      if (hit == 0) begin
         res.status   = ST_FIRST;
         res.position = '0;
      end else if (hit > 0) begin
         // Transpose: swap the hit with its neighbor one place ahead.
         swap_key             = shadow_keys[hit];
         shadow_keys[hit]     = shadow_keys[hit-1];
         shadow_keys[hit-1]   = swap_key;
         res.status           = ST_MOVED;
         res.position         = POSITION_WIDTH'(hit - 1);
      end else if (shadow_count >= CAPACITY) begin
         // Full: drop the key, leave the list alone, report position zero.
         res.status   = ST_DROPPED;
         res.position = '0;
      end else begin
         shadow_keys[shadow_count] = k;
         res.position              = POSITION_WIDTH'(shadow_count);
         shadow_count++;
         res.status                = ST_APPENDED;
      end
      res.entry_total = TOTAL_WIDTH'(shadow_count);
   endfunction

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Drive every block input to a known value from time zero.
   initial begin
      reset         = 1'b1;
      req_if.valid  = 1'b0;
      req_if.key    = '0;
      rsp_if.ready  = 1'b0;
      shadow_count  = 0;
      for (int i = 0; i < CAPACITY; i++) shadow_keys[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Request driver: present keys from the pending queue with random idle bursts.
   int gap_left;
   always @(posedge clock) begin
      list_outcome_type     outcome;
      bit                   next_valid;
      logic [KEY_WIDTH-1:0] next_key;
      if (reset) begin
         req_if.valid   <= 1'b0;
         gap_left       = 0;
         accepted_count = 0;
         drain_done     = 1'b0;
         quiet_phase    <= 1'b0;
      end else begin
         // Predict the response for the request taken at this edge.
         if (req_if.valid && req_if.ready) begin
            promote_key(req_if.key, outcome);
            expected_outcomes.push_back(outcome);
            accepted_count++;
         end
         // Load a new request only when the current one is gone.
         if (!req_if.valid || req_if.ready) begin
            next_valid = 1'b0;
            next_key   = req_if.key;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_keys.size() == 0) begin
               next_valid = 1'b0;
            end else if (accepted_count == DRAIN_AT && !drain_done) begin
               // Hold until the response side has caught up with every request.
               if (answered_count == accepted_count) drain_done = 1'b1;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 14) - 1;
            end else begin
               next_valid = 1'b1;
               next_key   = pending_keys.pop_front();
            end
            req_if.valid <= next_valid;
            req_if.key   <= next_key;
         end
         quiet_phase <= (pending_keys.size() < QUIET_TAIL);
      end
   end

   // Response monitor: stall ready in bursts and check each response taken.
   int stall_left;
   always @(posedge clock) begin
      list_outcome_type want;
      bit               next_ready;
      if (reset) begin
         rsp_if.ready   <= 1'b0;
         stall_left     = 0;
         mismatch_count = 0;
         answered_count <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            answered_count <= answered_count + 1;
            if (expected_outcomes.size() == 0) begin
               $display("%0t: response with nothing expected: status %0d position %0d total %0d",
                        $time, rsp_if.status, rsp_if.position, rsp_if.entry_total);
               mismatch_count++;
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_if.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_if.status);
                  mismatch_count++;
               end
               if (rsp_if.position !== want.position) begin
                  $display("%0t: position expected %0d actual %0d",
                           $time, want.position, rsp_if.position);
                  mismatch_count++;
               end
               if (rsp_if.entry_total !== want.entry_total) begin
                  $display("%0t: entry_total expected %0d actual %0d",
                           $time, want.entry_total, rsp_if.entry_total);
                  mismatch_count++;
               end
            end
         end
         next_ready = 1'b1;
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            next_ready = 1'b0;
         end
         rsp_if.ready <= next_ready;
      end
   end

   // Stimulus and end of run.
   initial begin
      int                   made;
      int                   pick;
      int                   burst;
      int                   waited;
      logic [KEY_WIDTH-1:0] key;

      // Directed: key zero as an ordinary key, a hit at the head, moves up to the head.
      pending_keys.push_back(8'h00);
      pending_keys.push_back(8'h00);
      pending_keys.push_back(8'hFF);
      pending_keys.push_back(8'hFF);
      pending_keys.push_back(8'hFF);
      pending_keys.push_back(8'h00);
      // Fill the list to capacity.
      for (int i = 2; i < CAPACITY; i++) pending_keys.push_back(fill_keys[i]);
      // Hit at the last slot, a dropped miss on a full list, a hit in the middle.
      pending_keys.push_back(8'h08);
      pending_keys.push_back(8'h99);
      pending_keys.push_back(8'h55);

      // Random: mostly hits on resident keys, some repeated to bubble a key to the
      // head, the rest arbitrary keys that usually miss and get dropped.
      made = 0;
      while (made < RANDOM_KEYS) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            key   = fill_keys[$urandom_range(0, CAPACITY - 1)];
            burst = $urandom_range(1, CAPACITY + 1);
            repeat (burst) pending_keys.push_back(key);
            made += burst;
         end else if (pick < 75) begin
            pending_keys.push_back(fill_keys[$urandom_range(0, CAPACITY - 1)]);
            made++;
         end else begin
            pending_keys.push_back(KEY_WIDTH'($urandom_range(0, 255)));
            made++;
         end
      end

      @(posedge clock);
      while (reset) @(posedge clock);
      // Advance until every request has been taken.
      while (pending_keys.size() != 0 || req_if.valid) @(posedge clock);
      waited = 0;
      while (expected_outcomes.size() != 0 && waited < END_WAIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_outcomes.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_outcomes.size());
         mismatch_count++;
      end
      // Let any stray response show up.
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
   end

endmodule

[filelist.f]
rtl/tsol_pkg.sv
rtl/tsol_req_if.sv
rtl/tsol_rsp_if.sv
rtl/tsol_cell.sv
rtl/tsol_match_reduce.sv
rtl/transpose_self_organizing_list.sv
sim/transpose_self_organizing_list_tb.sv
